### hw/rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg: shared constants, types and coefficient table
// Fixed-point formats, controller/datapath command bundle and the elaborated
// tangent series coefficient table (Q62).
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int FRAC_BITS     = 24;   // fraction bits of angle and tangent
    localparam int ANGLE_W       = 32;
    localparam int TAN_W         = 32;
    localparam int TOL_W         = 24;
    localparam int WORD_W        = 64;   // internal Q62 word

    localparam int MAX_TERMS_DEF = 16;
    localparam int MAX_TERMS_LIM = 32;
    localparam int COEF_DEPTH    = MAX_TERMS_LIM + 1;
    localparam int COEF_IDX_W    = $clog2(COEF_DEPTH);

    localparam int RED_SHIFT     = 62 - FRAC_BITS;          // Q24 -> Q62
    localparam int THR_SHIFT     = 61 - FRAC_BITS;          // tolerance * 2^(62-F) / 2
    localparam int REM_W         = ANGLE_W + RED_SHIFT;     // reduction remainder
    localparam int RED_STEPS     = 7;                       // quotient bits of angle / pi
    localparam int REC_STEPS     = TAN_W + 1;               // reciprocal quotient bits
    localparam int REC_TOP       = 62 + FRAC_BITS - REC_STEPS;
    localparam int Q_W           = REC_STEPS + 1;
    localparam int MUL_PARTS     = 4;                       // 32x32 partial products
    localparam int STEP_W        = $clog2(REC_STEPS);

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(17);

    localparam logic [WORD_W-1:0] PI_W  = 64'hC90F_DAA2_2168_C235;
    localparam logic [WORD_W-1:0] PIH_W = 64'h6487_ED51_10B4_611A;
    localparam logic [WORD_W-1:0] PIQ_W = 64'h3243_F6A8_885A_308D;
    localparam logic [WORD_W-1:0] ONE_W = 64'h4000_0000_0000_0000;

    typedef logic [COEF_IDX_W-1:0] t_coef_idx;
    typedef logic [COEF_DEPTH-1:0][WORD_W-1:0] t_coef_tab;

    typedef enum logic [1:0] {
        MUL_YY,     // y * y        -> y2
        MUL_CPW,    // c_n * y^k    -> term
        MUL_PWY2    // y^k * y2     -> next power
    } t_mul_op;

    typedef struct packed {
        logic            load;
        logic            red_step;
        logic [2:0]      red_shift;
        logic            setup;
        logic            fold;
        logic            mul_load;
        t_mul_op         mul_op;
        logic            mul_step;
        logic [1:0]      mul_part;
        logic            mul_wr;
        logic            term_add;
        t_coef_idx       coef_idx;
        logic            rec_init;
        logic            rec_step;
        logic            round;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic series;     // y above threshold: series needed
        logic inv;        // reciprocal path
        logic term_low;   // last term below threshold
        logic out_free;   // output register can take a word
    } t_dp_sts;

    // (a*b) >> 62
    function automatic logic [WORD_W-1:0] mulw(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return p[125:62];
    endfunction

    // restoring division, elaboration use only
    function automatic logic [WORD_W-1:0] udiv(input logic [WORD_W-1:0] num,
                                               input logic [WORD_W-1:0] den);
        logic [WORD_W:0]   rem;
        logic [WORD_W-1:0] quo;
        int                i;
        rem = '0;
        quo = '0;
        for (i = WORD_W - 1; i >= 0; i--) begin
            rem = {rem[WORD_W-1:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // c_1 = 1, (2n-1) c_n = sum c_i c_(n-i), rounded to nearest
    function automatic t_coef_tab coef_table();
        t_coef_tab         c;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] d;
        int                n;
        int                i;
        c    = '0;
        c[1] = ONE_W;
        for (n = 2; n < COEF_DEPTH; n++) begin
            acc = '0;
            for (i = 1; i < n; i++) begin
                acc = acc + mulw(c[i], c[n-i]);
            end
            d    = WORD_W'(2 * n - 1);
            c[n] = udiv(acc + (d >> 1), d);
        end
        return c;
    endfunction

    localparam t_coef_tab COEF_TAB = coef_table();

endpackage

### hw/rtl/tse_ctrl.sv
// ----------------------------------------------------------------------------
// tse_ctrl: sequencing state machine
// Steps the datapath through reduction, series, reciprocal and rounding.
// ----------------------------------------------------------------------------
module tse_ctrl #(
    parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tse_pkg::t_dp_sts i_sts,
    output tse_pkg::t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_SETUP, S_FOLD, S_DECIDE, S_MLOAD, S_MRUN, S_MWR,
        S_TADD, S_RINIT, S_RRUN, S_ROUND, S_OUT
    } t_state;

    t_state                       r_state, n_state;
    logic [tse_pkg::STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]             r_term, n_term;
    tse_pkg::t_mul_op             r_op, n_op;
    logic                         r_in_stall, n_in_stall;

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_term        = r_term;
        n_op          = r_op;
        o_cmd         = '0;
        o_cmd.mul_op  = r_op;
        o_cmd.coef_idx = tse_pkg::t_coef_idx'(r_term);
        o_cmd.red_shift = 3'(tse_pkg::RED_STEPS - 1) - r_step[2:0];
        o_cmd.mul_part  = r_step[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == tse_pkg::STEP_W'(tse_pkg::RED_STEPS - 1)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.series) begin
                    n_op    = tse_pkg::MUL_YY;
                    n_term  = CNT_W'(1);
                    n_state = S_MLOAD;
                end else if (i_sts.inv) begin
                    n_state = S_RINIT;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_MLOAD: begin
                o_cmd.mul_load = 1'b1;
                n_step         = '0;
                n_state        = S_MRUN;
            end
            S_MRUN: begin
                o_cmd.mul_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == tse_pkg::STEP_W'(tse_pkg::MUL_PARTS - 1)) begin
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                o_cmd.mul_wr = 1'b1;
                unique case (r_op)
                    tse_pkg::MUL_YY: begin
                        n_op    = tse_pkg::MUL_CPW;
                        n_state = S_MLOAD;
                    end
                    tse_pkg::MUL_CPW: begin
                        n_state = S_TADD;
                    end
                    tse_pkg::MUL_PWY2: begin
                        n_term  = r_term + 1'b1;
                        n_op    = tse_pkg::MUL_CPW;
                        n_state = S_MLOAD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_TADD: begin
                o_cmd.term_add = 1'b1;
                if (i_sts.term_low || (r_term == CNT_W'(MAX_TERMS))) begin
                    n_state = i_sts.inv ? S_RINIT : S_ROUND;
                end else begin
                    n_op    = tse_pkg::MUL_PWY2;
                    n_state = S_MLOAD;
                end
            end
            S_RINIT: begin
                o_cmd.rec_init = 1'b1;
                n_step         = '0;
                n_state        = S_RRUN;
            end
            S_RRUN: begin
                o_cmd.rec_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == tse_pkg::STEP_W'(tse_pkg::REC_STEPS - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_term     <= '0;
            r_op       <= tse_pkg::MUL_YY;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_term     <= n_term;
            r_op       <= n_op;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

### hw/rtl/tse_dpath.sv
// ----------------------------------------------------------------------------
// tse_dpath: tangent datapath
// Reduction remainder, shared 64x64 multiplier (one 32x32 product a cycle),
// shift-subtract divider, series accumulator and output register.
// ----------------------------------------------------------------------------
module tse_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [tse_pkg::TOL_W-1:0]   i_cfg_wdata,
    input  logic signed [tse_pkg::ANGLE_W-1:0] i_angle,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic signed [tse_pkg::TAN_W-1:0]   o_tangent,
    output logic                        o_saturated,
    input  tse_pkg::t_dp_cmd            i_cmd,
    output tse_pkg::t_dp_sts            o_sts
);

    localparam int W    = tse_pkg::WORD_W;
    localparam int CW   = W + 4;                       // room for 5*x + 5
    localparam int THRW = tse_pkg::TOL_W + tse_pkg::THR_SHIFT;

    logic [tse_pkg::TOL_W-1:0] r_tol;
    logic [tse_pkg::REM_W-1:0] r_rem;
    logic                      r_nin, r_neg, r_inv;
    logic [W-1:0]              r_y, r_y2, r_pw, r_term, r_sum, r_t;
    logic [W-1:0]              r_ma, r_mb;
    logic [2*W-1:0]            r_macc;
    logic [tse_pkg::Q_W-1:0]   r_q;
    logic                      r_ovalid;
    logic [tse_pkg::TAN_W-1:0] r_tangent;
    logic                      r_sat;

    logic [tse_pkg::ANGLE_W-1:0] m;
    logic [tse_pkg::REM_W-1:0]   dsub;
    logic [W-1:0]                rr;
    logic                        zneg, inv;
    logic [W-1:0]                yv;
    logic [THRW-1:0]             thr;
    logic [CW-1:0]               y5, term5;
    logic [31:0]                 ah, bh;
    logic [W-1:0]                pp;
    logic [2*W-1:0]              pps;
    logic [W-1:0]                mres;
    logic [W:0]                  rem2;
    logic                        ge, half, cap;
    logic [W:0]                  rnd;
    logic [tse_pkg::Q_W-1:0]     limit, qs;
    logic                        sat;

    // sign-magnitude of the angle; -(-2^31) reads as 2^31 unsigned
    assign m    = i_angle[tse_pkg::ANGLE_W-1] ? (tse_pkg::ANGLE_W'(0) - i_angle) : i_angle;
    assign dsub = tse_pkg::REM_W'(tse_pkg::PI_W) << i_cmd.red_shift;

    // remainder in [0, pi): fold to signed window, then to magnitude
    assign rr   = r_rem[W-1:0];
    assign zneg = rr > tse_pkg::PIH_W;
    assign inv  = r_y > tse_pkg::PIQ_W;
    assign yv   = inv ? (tse_pkg::PIH_W - r_y) : r_y;

    // y > tol/10  <=>  5y > tol*2^(61-F), avoids a divide
    assign thr   = {r_tol, {tse_pkg::THR_SHIFT{1'b0}}};
    assign y5    = ({4'd0, r_y} << 2) + {4'd0, r_y};
    assign term5 = ({4'd0, r_term} << 2) + {4'd0, r_term} + CW'(5);

    // partial product select
    assign ah   = i_cmd.mul_part[1] ? r_ma[W-1:32] : r_ma[31:0];
    assign bh   = i_cmd.mul_part[0] ? r_mb[W-1:32] : r_mb[31:0];
    assign pp   = {32'd0, ah} * {32'd0, bh};
    assign pps  = {{W{1'b0}}, pp} << (7'd32 * (7'(i_cmd.mul_part[1]) + 7'(i_cmd.mul_part[0])));
    assign mres = r_macc[125:62];

    assign rem2 = {r_rem[W-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, r_t};
    assign half = rem2 >= {1'b0, r_t};
    assign cap  = r_t <= (W'(1) << tse_pkg::REC_TOP);
    assign rnd  = {1'b0, r_t} + ((W + 1)'(1) << (tse_pkg::RED_SHIFT - 1));

    assign limit = r_neg ? (tse_pkg::Q_W'(1) << (tse_pkg::TAN_W - 1))
                         : ((tse_pkg::Q_W'(1) << (tse_pkg::TAN_W - 1)) - 1'b1);
    assign sat   = r_q > limit;
    assign qs    = sat ? limit : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= tse_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nin <= i_angle[tse_pkg::ANGLE_W-1];
            r_rem <= {m, {tse_pkg::RED_SHIFT{1'b0}}};
        end
        if (i_cmd.red_step && (r_rem >= dsub)) begin
            r_rem <= r_rem - dsub;
        end
        if (i_cmd.setup) begin
            r_y   <= zneg ? (tse_pkg::PI_W - rr) : rr;
            r_neg <= r_nin ^ zneg;
        end
        if (i_cmd.fold) begin
            r_inv <= inv;
            r_y   <= yv;
            r_pw  <= yv;
            r_t   <= yv;
            r_sum <= '0;
        end
        if (i_cmd.mul_load) begin
            r_macc <= '0;
            unique case (i_cmd.mul_op)
                tse_pkg::MUL_YY: begin
                    r_ma <= r_y;
                    r_mb <= r_y;
                end
                tse_pkg::MUL_CPW: begin
                    r_ma <= tse_pkg::COEF_TAB[i_cmd.coef_idx];
                    r_mb <= r_pw;
                end
                tse_pkg::MUL_PWY2: begin
                    r_ma <= r_pw;
                    r_mb <= r_y2;
                end
                default: begin
                    r_ma <= '0;
                    r_mb <= '0;
                end
            endcase
        end
        if (i_cmd.mul_step) begin
            r_macc <= r_macc + pps;
        end
        if (i_cmd.mul_wr) begin
            unique case (i_cmd.mul_op)
                tse_pkg::MUL_YY:   r_y2   <= mres;
                tse_pkg::MUL_CPW:  r_term <= mres;
                tse_pkg::MUL_PWY2: r_pw   <= mres;
                default:           r_term <= mres;
            endcase
        end
        if (i_cmd.term_add) begin
            r_sum <= r_sum + r_term;
            r_t   <= r_sum + r_term;
        end
        if (i_cmd.rec_init) begin
            r_rem <= tse_pkg::REM_W'(1) << tse_pkg::REC_TOP;
            r_q   <= '0;
        end
        if (i_cmd.rec_step) begin
            r_rem <= tse_pkg::REM_W'(ge ? (rem2 - {1'b0, r_t}) : rem2);
            r_q   <= {r_q[tse_pkg::Q_W-2:0], ge};
        end
        if (i_cmd.round) begin
            if (r_inv) begin
                r_q <= cap ? (tse_pkg::Q_W'(1) << tse_pkg::TAN_W)
                           : (r_q + tse_pkg::Q_W'(half));
            end else begin
                r_q <= tse_pkg::Q_W'(rnd >> tse_pkg::RED_SHIFT);
            end
        end
        if (i_cmd.out_load) begin
            r_tangent <= r_neg ? (tse_pkg::TAN_W'(0) - qs[tse_pkg::TAN_W-1:0])
                               : qs[tse_pkg::TAN_W-1:0];
            r_sat     <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.series   = y5 > CW'(thr);
    assign o_sts.inv      = r_inv;
    assign o_sts.term_low = term5 <= CW'(thr);
    assign o_sts.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_tangent   = r_tangent;
    assign o_saturated = r_sat;

endmodule

### hw/rtl/tangent_series_evaluator.sv
// ----------------------------------------------------------------------------
// tangent_series_evaluator: fixed-point tangent by Taylor series
// Reduces a Q24 angle modulo pi, folds magnitudes above pi/4 onto 1/tan,
// sums the Bernoulli-coefficient series on one shared multiplier and
// saturates the Q24 result.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------
//  in       | to block  | i_in_valid / o_in_stall      | i_angle (s32, Q24)
//  out      | from block| o_out_valid / i_out_stall    | o_tangent (s32), o_saturated
//  cfg      | to block  | i_cfg_valid / o_cfg_ready    | i_cfg_wdata (tolerance)
//
// One word at a time. An accepted word runs through reduction and the fold,
// then, if needed, a series of up to MAX_TERMS terms (16 by default; each 64x64
// product is built from 32x32 partial products on the single multiplier), then,
// for magnitudes above pi/4, the reciprocal divider, and lands in the output register.
// Reset is synchronous, active low; tolerance returns to 17.
// The next word is accepted once the result sits in the output register,
// even while i_out_stall holds it; a full output register holds the sequencer.
// ----------------------------------------------------------------------------
module tangent_series_evaluator #(
    parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tse_pkg::TOL_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [tse_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [tse_pkg::TAN_W-1:0]   o_tangent,
    output logic                               o_saturated
);

    tse_pkg::t_dp_cmd cmd;
    tse_pkg::t_dp_sts sts;

    // tolerance register is always writable
    assign o_cfg_ready = 1'b1;

    tse_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tse_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_wdata (i_cfg_wdata),
        .i_angle     (i_angle),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_tangent   (o_tangent),
        .o_saturated (o_saturated),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

### hw/rtl/tse_chk.sv
// ----------------------------------------------------------------------------
// tse_chk: port-level checks
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tse_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [tse_pkg::TOL_W-1:0]          i_cfg_wdata,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic signed [tse_pkg::ANGLE_W-1:0] i_angle,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [tse_pkg::TAN_W-1:0]   o_tangent,
    input logic                               o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_tangent) && $stable(o_saturated))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before work started");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_tangent == 32'sh7FFF_FFFF || o_tangent == 32'sh8000_0000))
        else $error("saturated word is not a range limit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left a word pending");

endmodule

bind tangent_series_evaluator tse_chk u_tse_chk (.*);
